### rtl/core/vbsd_pkg.sv
// ----------------------------------------------------------------------------
// vbsd_pkg
// Shared widths, register indexes and the work item passed from the walker
// to the accumulator.
// ----------------------------------------------------------------------------
package vbsd_pkg;

    localparam int PLANE_ACC_DEPTH = 4096;
    localparam int MAX_BLOCK       = 16;

    localparam int SIZE_W       = 13;
    localparam int SIZE_MAX_EXT = 4096;
    localparam int BLOCK_REG_W  = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int SAMPLE_W     = 32;
    localparam int SUM_W        = 48;
    localparam int COORD_W      = 12;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_Z = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
        logic                       last;
        logic [COORD_W-1:0]         x;
        logic [COORD_W-1:0]         y;
        logic [COORD_W-1:0]         z;
        logic                       done;
    } vbsd_item_t;

    localparam int ITEM_W = $bits(vbsd_item_t);

    // Clamp a size register: zero acts as one, anything past the limit as the limit.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > SIZE_W'(SIZE_MAX_EXT))
        begin
            r = SIZE_W'(SIZE_MAX_EXT);
        end
        return r;
    endfunction

endpackage

### rtl/core/volume_block_sum_downsampler_core.sv
// ----------------------------------------------------------------------------
// volume_block_sum_downsampler_core
// 3D box-binning sum decimator for signed Q16.16 volume samples.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while in_stall is low, in memory order (x
// fastest, then y, then z) and emits one 48-bit sum per whole block_x by
// block_y by block_z block through the queue, accumulator stage and output
// register, delayed while earlier work waits on a stalled output; samples
// of partial edge blocks are consumed without a result. The rate is set by
// the plane accumulator: one read and one write per cycle unless a final
// sample waits on a stalled output, the previous write forwarded to the next
// sample. No clearing pass: the first sample of every block writes its entry.
// A write to any size or block register restarts the walk at the volume origin.
// ----------------------------------------------------------------------------
module volume_block_sum_downsampler_core #(
    parameter int PLANE_ACC_DEPTH = vbsd_pkg::PLANE_ACC_DEPTH,
    parameter int MAX_BLOCK       = vbsd_pkg::MAX_BLOCK
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [vbsd_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [vbsd_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [vbsd_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [vbsd_pkg::SUM_W-1:0]    block_sum,
    output logic [vbsd_pkg::COORD_W-1:0]         out_x,
    output logic [vbsd_pkg::COORD_W-1:0]         out_y,
    output logic [vbsd_pkg::COORD_W-1:0]         out_z,
    output logic                                 volume_done
);
    import vbsd_pkg::*;

    localparam int AW = $clog2(PLANE_ACC_DEPTH);
    localparam int QW = ITEM_W + AW;

    logic             push, pop, q_full, q_valid;
    vbsd_item_t       push_item, q_item;
    logic [AW-1:0]    push_addr, q_addr;
    logic [QW-1:0]    q_rdata;

    assign in_stall = q_full;

    vbsd_front #(
        .PLANE_ACC_DEPTH(PLANE_ACC_DEPTH),
        .MAX_BLOCK      (MAX_BLOCK)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_valid (in_valid),
        .sample   (sample),
        .q_full   (q_full),
        .push     (push),
        .push_item(push_item),
        .push_addr(push_addr)
    );

    vbsd_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data({push_addr, push_item}),
        .pop      (pop),
        .pop_data (q_rdata),
        .not_empty(q_valid),
        .full     (q_full)
    );

    assign q_item = vbsd_item_t'(q_rdata[ITEM_W-1:0]);
    assign q_addr = q_rdata[QW-1:ITEM_W];

    vbsd_back #(
        .PLANE_ACC_DEPTH(PLANE_ACC_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_addr     (q_addr),
        .q_pop      (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_sum  (block_sum),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .volume_done(volume_done)
    );

endmodule

### rtl/core/vbsd_queue.sv
// ----------------------------------------------------------------------------
// vbsd_queue
// Small register FIFO between the walker and the accumulator.
// ----------------------------------------------------------------------------
module vbsd_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = vbsd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic             full
);
    import vbsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign pop_data  = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/vbsd_front.sv
// ----------------------------------------------------------------------------
// vbsd_front
// Holds the configuration, walks the volume in memory order and classifies
// each sample: dropped when its block is partial, otherwise tagged with its
// accumulator address, block coordinates and first/last/done marks.
// ----------------------------------------------------------------------------
module vbsd_front #(
    parameter int PLANE_ACC_DEPTH = vbsd_pkg::PLANE_ACC_DEPTH,
    parameter int MAX_BLOCK       = vbsd_pkg::MAX_BLOCK,
    localparam int AW             = $clog2(PLANE_ACC_DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [vbsd_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [vbsd_pkg::CFG_DATA_W-1:0]     wr_data,
    input  logic                                in_valid,
    input  logic signed [vbsd_pkg::SAMPLE_W-1:0] sample,
    input  logic                                q_full,
    output logic                                push,
    output vbsd_pkg::vbsd_item_t                push_item,
    output logic [AW-1:0]                       push_addr
);
    import vbsd_pkg::*;

    localparam int BW    = $clog2(MAX_BLOCK + 1);
    localparam int EXT_W = SIZE_W + 1;

    function automatic logic [BW-1:0] eff_block(input logic [BLOCK_REG_W-1:0] v);
        int unsigned t;
        t = 32'(v);
        if (t == 0)
        begin
            t = 1;
        end
        else if (t > MAX_BLOCK)
        begin
            t = MAX_BLOCK;
        end
        return BW'(t);
    endfunction

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW + 1)'(PLANE_ACC_DEPTH))
        begin
            s = s - (AW + 1)'(PLANE_ACC_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // configuration
    logic [SIZE_W-1:0]      size_x_reg, size_y_reg, size_z_reg;
    logic [BLOCK_REG_W-1:0] block_x_reg, block_y_reg, block_z_reg;

    // walk state
    logic [COORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [COORD_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [BW-1:0]      sub_x_reg, sub_y_reg, sub_z_reg;
    logic [BW-1:0]      sub_x_next, sub_y_next, sub_z_next;
    logic [COORD_W-1:0] blk_x_reg, blk_y_reg, blk_z_reg;
    logic [COORD_W-1:0] blk_x_next, blk_y_next, blk_z_next;
    logic [SIZE_W-1:0]  base_x_reg, base_y_reg, base_z_reg;
    logic [SIZE_W-1:0]  base_x_next, base_y_next, base_z_next;
    logic [AW-1:0]      col_reg, col_next;
    logic [AW-1:0]      row_reg, row_next;

    logic [SIZE_W-1:0] sx, sy, sz;
    logic [BW-1:0]     bx, by, bz;
    logic              accept, cfg_hit;
    logic              whole_x, whole_y, whole_z;
    logic              last_x, last_y, last_z;
    logic [BW:0]       sub_x_inc, sub_y_inc, sub_z_inc;
    logic              wrap_x, wrap_y, wrap_z;
    logic [SIZE_W-1:0] pos_x_inc, pos_y_inc, pos_z_inc;
    logic              end_x, end_y, end_z;
    logic [AW-1:0]     col_inc, nx_mod;

    assign sx = eff_size(size_x_reg);
    assign sy = eff_size(size_y_reg);
    assign sz = eff_size(size_z_reg);
    assign bx = eff_block(block_x_reg);
    assign by = eff_block(block_y_reg);
    assign bz = eff_block(block_z_reg);

    assign accept  = in_valid && !q_full;
    assign cfg_hit = wr_en && (wr_index == REG_SIZE_X || wr_index == REG_SIZE_Y ||
                               wr_index == REG_SIZE_Z || wr_index == REG_BLOCK_X ||
                               wr_index == REG_BLOCK_Y || wr_index == REG_BLOCK_Z);

    // a block is whole when it ends inside the volume; it is the last one on
    // its axis when a further block would not fit
    assign whole_x = ({1'b0, base_x_reg} + EXT_W'(bx)) <= {1'b0, sx};
    assign whole_y = ({1'b0, base_y_reg} + EXT_W'(by)) <= {1'b0, sy};
    assign whole_z = ({1'b0, base_z_reg} + EXT_W'(bz)) <= {1'b0, sz};
    assign last_x  = ({1'b0, base_x_reg} + EXT_W'(bx) + EXT_W'(bx)) > {1'b0, sx};
    assign last_y  = ({1'b0, base_y_reg} + EXT_W'(by) + EXT_W'(by)) > {1'b0, sy};
    assign last_z  = ({1'b0, base_z_reg} + EXT_W'(bz) + EXT_W'(bz)) > {1'b0, sz};

    assign sub_x_inc = {1'b0, sub_x_reg} + (BW + 1)'(1);
    assign sub_y_inc = {1'b0, sub_y_reg} + (BW + 1)'(1);
    assign sub_z_inc = {1'b0, sub_z_reg} + (BW + 1)'(1);
    assign wrap_x    = sub_x_inc >= {1'b0, bx};
    assign wrap_y    = sub_y_inc >= {1'b0, by};
    assign wrap_z    = sub_z_inc >= {1'b0, bz};

    assign pos_x_inc = {1'b0, pos_x_reg} + SIZE_W'(1);
    assign pos_y_inc = {1'b0, pos_y_reg} + SIZE_W'(1);
    assign pos_z_inc = {1'b0, pos_z_reg} + SIZE_W'(1);
    assign end_x     = pos_x_inc >= sx;
    assign end_y     = pos_y_inc >= sy;
    assign end_z     = pos_z_inc >= sz;

    // column counter modulo the plane depth; at the end of a line its
    // advanced value is the count of whole blocks across x
    assign col_inc = (col_reg == AW'(PLANE_ACC_DEPTH - 1)) ? '0 : col_reg + AW'(1);
    assign nx_mod  = wrap_x ? col_inc : col_reg;

    assign push                = accept && whole_x && whole_y && whole_z;
    assign push_addr           = wrap_add(row_reg, col_reg);
    assign push_item.sample    = sample;
    assign push_item.first     = (sub_x_reg == '0) && (sub_y_reg == '0) && (sub_z_reg == '0);
    assign push_item.last      = wrap_x && wrap_y && wrap_z;
    assign push_item.x         = blk_x_reg;
    assign push_item.y         = blk_y_reg;
    assign push_item.z         = blk_z_reg;
    assign push_item.done      = last_x && last_y && last_z;

    always_comb
    begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        pos_z_next  = pos_z_reg;
        sub_x_next  = sub_x_reg;
        sub_y_next  = sub_y_reg;
        sub_z_next  = sub_z_reg;
        blk_x_next  = blk_x_reg;
        blk_y_next  = blk_y_reg;
        blk_z_next  = blk_z_reg;
        base_x_next = base_x_reg;
        base_y_next = base_y_reg;
        base_z_next = base_z_reg;
        col_next    = col_reg;
        row_next    = row_reg;

        if (cfg_hit)
        begin
            // restart the walk at the volume origin
            pos_x_next  = '0;
            pos_y_next  = '0;
            pos_z_next  = '0;
            sub_x_next  = '0;
            sub_y_next  = '0;
            sub_z_next  = '0;
            blk_x_next  = '0;
            blk_y_next  = '0;
            blk_z_next  = '0;
            base_x_next = '0;
            base_y_next = '0;
            base_z_next = '0;
            col_next    = '0;
            row_next    = '0;
        end
        else if (accept)
        begin
            if (!end_x)
            begin
                pos_x_next = pos_x_inc[COORD_W-1:0];
                if (wrap_x)
                begin
                    sub_x_next  = '0;
                    blk_x_next  = blk_x_reg + COORD_W'(1);
                    base_x_next = base_x_reg + SIZE_W'(bx);
                    col_next    = col_inc;
                end
                else
                begin
                    sub_x_next = sub_x_inc[BW-1:0];
                end
            end
            else
            begin
                pos_x_next  = '0;
                sub_x_next  = '0;
                blk_x_next  = '0;
                base_x_next = '0;
                col_next    = '0;
                if (!end_y)
                begin
                    pos_y_next = pos_y_inc[COORD_W-1:0];
                    if (wrap_y)
                    begin
                        sub_y_next  = '0;
                        blk_y_next  = blk_y_reg + COORD_W'(1);
                        base_y_next = base_y_reg + SIZE_W'(by);
                        row_next    = wrap_add(row_reg, nx_mod);
                    end
                    else
                    begin
                        sub_y_next = sub_y_inc[BW-1:0];
                    end
                end
                else
                begin
                    pos_y_next  = '0;
                    sub_y_next  = '0;
                    blk_y_next  = '0;
                    base_y_next = '0;
                    row_next    = '0;
                    if (!end_z)
                    begin
                        pos_z_next = pos_z_inc[COORD_W-1:0];
                        if (wrap_z)
                        begin
                            sub_z_next  = '0;
                            blk_z_next  = blk_z_reg + COORD_W'(1);
                            base_z_next = base_z_reg + SIZE_W'(bz);
                        end
                        else
                        begin
                            sub_z_next = sub_z_inc[BW-1:0];
                        end
                    end
                    else
                    begin
                        pos_z_next  = '0;
                        sub_z_next  = '0;
                        blk_z_next  = '0;
                        base_z_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg  <= SIZE_W'(1);
            size_y_reg  <= SIZE_W'(1);
            size_z_reg  <= SIZE_W'(1);
            block_x_reg <= BLOCK_REG_W'(1);
            block_y_reg <= BLOCK_REG_W'(1);
            block_z_reg <= BLOCK_REG_W'(1);
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            sub_x_reg   <= '0;
            sub_y_reg   <= '0;
            sub_z_reg   <= '0;
            blk_x_reg   <= '0;
            blk_y_reg   <= '0;
            blk_z_reg   <= '0;
            base_x_reg  <= '0;
            base_y_reg  <= '0;
            base_z_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_SIZE_X:  size_x_reg  <= wr_data;
                    REG_SIZE_Y:  size_y_reg  <= wr_data;
                    REG_SIZE_Z:  size_z_reg  <= wr_data;
                    REG_BLOCK_X: block_x_reg <= wr_data[BLOCK_REG_W-1:0];
                    REG_BLOCK_Y: block_y_reg <= wr_data[BLOCK_REG_W-1:0];
                    REG_BLOCK_Z: block_z_reg <= wr_data[BLOCK_REG_W-1:0];
                    default:     ;
                endcase
            end
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            sub_x_reg  <= sub_x_next;
            sub_y_reg  <= sub_y_next;
            sub_z_reg  <= sub_z_next;
            blk_x_reg  <= blk_x_next;
            blk_y_reg  <= blk_y_next;
            blk_z_reg  <= blk_z_next;
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
            base_z_reg <= base_z_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

### rtl/core/vbsd_back.sv
// ----------------------------------------------------------------------------
// vbsd_back
// Plane accumulator: registered read of the block entry, add with forwarding
// from the previous write, write back, and an output register for block sums.
// ----------------------------------------------------------------------------
module vbsd_back #(
    parameter int PLANE_ACC_DEPTH = vbsd_pkg::PLANE_ACC_DEPTH,
    localparam int AW             = $clog2(PLANE_ACC_DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  vbsd_pkg::vbsd_item_t               q_item,
    input  logic [AW-1:0]                      q_addr,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [vbsd_pkg::SUM_W-1:0]  block_sum,
    output logic [vbsd_pkg::COORD_W-1:0]       out_x,
    output logic [vbsd_pkg::COORD_W-1:0]       out_y,
    output logic [vbsd_pkg::COORD_W-1:0]       out_z,
    output logic                               volume_done
);
    import vbsd_pkg::*;

    logic [SUM_W-1:0] acc_mem [PLANE_ACC_DEPTH];

    logic             s2_valid_reg;
    vbsd_item_t       s2_item_reg;
    logic [AW-1:0]    s2_addr_reg;
    logic [SUM_W-1:0] rd_data_reg;
    logic             fwd_hit_reg;
    logic [SUM_W-1:0] fwd_sum_reg;

    logic             out_valid_reg;
    logic [SUM_W-1:0] sum_out_reg;
    logic [COORD_W-1:0] x_out_reg, y_out_reg, z_out_reg;
    logic             done_out_reg;

    logic             out_free, s2_adv, load;
    logic [SUM_W-1:0] acc_base, sum;

    assign out_free = !out_valid_reg || !out_stall;
    // a non-final sample of a block leaves no result and never waits on the output
    assign s2_adv   = s2_valid_reg && (!s2_item_reg.last || out_free);
    assign load     = q_valid && (!s2_valid_reg || s2_adv);
    assign q_pop    = load;

    always_comb
    begin
        if (s2_item_reg.first)
        begin
            acc_base = '0;
        end
        else if (fwd_hit_reg)
        begin
            acc_base = fwd_sum_reg;
        end
        else
        begin
            acc_base = rd_data_reg;
        end
        sum = acc_base + {{(SUM_W - SAMPLE_W){s2_item_reg.sample[SAMPLE_W-1]}},
                          s2_item_reg.sample};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv && s2_item_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_item_reg <= q_item;
            s2_addr_reg <= q_addr;
            rd_data_reg <= acc_mem[q_addr];
            // the entry read at this edge misses a write landing at the same edge
            fwd_hit_reg <= s2_adv && (s2_addr_reg == q_addr);
            fwd_sum_reg <= sum;
        end
        if (s2_adv)
        begin
            acc_mem[s2_addr_reg] <= sum;
        end
        if (s2_adv && s2_item_reg.last)
        begin
            sum_out_reg  <= sum;
            x_out_reg    <= s2_item_reg.x;
            y_out_reg    <= s2_item_reg.y;
            z_out_reg    <= s2_item_reg.z;
            done_out_reg <= s2_item_reg.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_sum   = sum_out_reg;
    assign out_x       = x_out_reg;
    assign out_y       = y_out_reg;
    assign out_z       = z_out_reg;
    assign volume_done = done_out_reg;

endmodule

### rtl/core/vbsd_checker.sv
// ----------------------------------------------------------------------------
// vbsd_checker
// Port-level checks on the decimator, bound to the top level.
// ----------------------------------------------------------------------------
module vbsd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [vbsd_pkg::SUM_W-1:0]    block_sum,
    input logic [vbsd_pkg::COORD_W-1:0]         out_x,
    input logic [vbsd_pkg::COORD_W-1:0]         out_y,
    input logic [vbsd_pkg::COORD_W-1:0]         out_z,
    input logic                                 volume_done
);
    import vbsd_pkg::*;

    // a result waiting on a stall stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(block_sum) && $stable(out_x) &&
        $stable(out_y) && $stable(out_z) && $stable(volume_done))
        else $error("stalled result changed");

    // the input side only backs up after a sample was offered
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall without a prior sample");

    // leaving reset, nothing is pending on either side
    a_reset_clean: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("state left over after reset");

endmodule

bind volume_block_sum_downsampler_core vbsd_checker u_vbsd_checker (.*);

### bench/volume_block_sum_downsampler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_block_sum_downsampler_core_tb
// Self-checking bench for the 3D block-sum decimator.
// ----------------------------------------------------------------------------
// Walks a table of directed samples and register writes, then random volume
// geometries with random samples, a backpressure burst and pauses that let
// the output empty. An internal walk/accumulate model predicts each block
// sum; every result transfer is checked field by field, in order.
// ----------------------------------------------------------------------------
module volume_block_sum_downsampler_core_tb;

    import vbsd_pkg::*;

    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 64;
    localparam int PRINT_LIMIT   = 100;
    localparam int TIMEOUT_NS    = 30_000_000;

    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_B = 3'd7;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               done;
    } block_result_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   value;
        block_result_t         expected;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]       wr_index  = '0;
    logic [CFG_DATA_W-1:0]      wr_data   = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SUM_W-1:0]    block_sum;
    logic [COORD_W-1:0]         out_x;
    logic [COORD_W-1:0]         out_y;
    logic [COORD_W-1:0]         out_z;
    logic                       volume_done;

    // Model state: raw register contents, walk position and the plane of sums
    logic [CFG_DATA_W-1:0]  reg_size [3] = '{13'd1, 13'd1, 13'd1};
    logic [BLOCK_REG_W-1:0] reg_block [3] = '{5'd1, 5'd1, 5'd1};
    int                     walk_pos [3];
    int                     walk_sub [3];
    int                     walk_blk [3];
    logic [SUM_W-1:0]       plane_sums [PLANE_ACC_DEPTH];

    block_result_t pending_sums [$];
    stim_row_t     directed_rows [$];
    int            error_count = 0;
    int            burst_left  = 0;
    int            hold_token  = 0;

    volume_block_sum_downsampler_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .block_sum   (block_sum),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .volume_done (volume_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int size_extent(input logic [CFG_DATA_W-1:0] code);
        if (code == '0)
        begin
            return 1;
        end
        return (code > SIZE_MAX_EXT) ? SIZE_MAX_EXT : int'(code);
    endfunction

    function automatic int block_extent(input logic [BLOCK_REG_W-1:0] code);
        if (code == '0)
        begin
            return 1;
        end
        return (code > MAX_BLOCK) ? MAX_BLOCK : int'(code);
    endfunction

    // Fold one sample into the plane and advance the walk; flag a finished block
    task automatic accumulate_block_sum(input logic [SAMPLE_W-1:0] value,
                                        output bit produced, output block_result_t res);
        int               ext_size [3];
        int               ext_blk [3];
        int               nblk [3];
        int               addr;
        int               axis;
        bit               carry;
        logic [SUM_W-1:0] wide;
        produced = 1'b0;
        res      = '0;
        for (axis = 0; axis < 3; axis++)
        begin
            ext_size[axis] = size_extent(reg_size[axis]);
            ext_blk[axis]  = block_extent(reg_block[axis]);
            nblk[axis]     = ext_size[axis] / ext_blk[axis];
        end
        wide = {{(SUM_W - SAMPLE_W){value[SAMPLE_W-1]}}, value};
        if (walk_blk[0] < nblk[0] && walk_blk[1] < nblk[1] && walk_blk[2] < nblk[2])
        begin
            addr = (walk_blk[1] * nblk[0] + walk_blk[0]) % PLANE_ACC_DEPTH;
            // the first sample of a block overwrites whatever the entry held
            if (walk_sub[0] == 0 && walk_sub[1] == 0 && walk_sub[2] == 0)
            begin
                plane_sums[addr] = wide;
            end
            else
            begin
                plane_sums[addr] = plane_sums[addr] + wide;
            end
            if (walk_sub[0] == ext_blk[0] - 1 && walk_sub[1] == ext_blk[1] - 1 &&
                walk_sub[2] == ext_blk[2] - 1)
            begin
                produced = 1'b1;
                res.sum  = plane_sums[addr];
                res.x    = COORD_W'(walk_blk[0]);
                res.y    = COORD_W'(walk_blk[1]);
                res.z    = COORD_W'(walk_blk[2]);
                res.done = (walk_blk[0] == nblk[0] - 1 && walk_blk[1] == nblk[1] - 1 &&
                            walk_blk[2] == nblk[2] - 1);
            end
        end
        carry = 1'b1;
        for (axis = 0; axis < 3; axis++)
        begin
            if (carry)
            begin
                walk_pos[axis]++;
                walk_sub[axis]++;
                if (walk_sub[axis] >= ext_blk[axis])
                begin
                    walk_sub[axis] = 0;
                    walk_blk[axis]++;
                end
                carry = (walk_pos[axis] >= ext_size[axis]);
                if (carry)
                begin
                    walk_pos[axis] = 0;
                    walk_sub[axis] = 0;
                    walk_blk[axis] = 0;
                end
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        int axis;
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(posedge clk);
        case (index)
            REG_SIZE_X:  reg_size[0]  = data;
            REG_SIZE_Y:  reg_size[1]  = data;
            REG_SIZE_Z:  reg_size[2]  = data;
            REG_BLOCK_X: reg_block[0] = data[BLOCK_REG_W-1:0];
            REG_BLOCK_Y: reg_block[1] = data[BLOCK_REG_W-1:0];
            REG_BLOCK_Z: reg_block[2] = data[BLOCK_REG_W-1:0];
            default: ;
        endcase
        // any real register restarts the walk; spare indexes leave it alone
        if (index <= REG_BLOCK_Z)
        begin
            for (axis = 0; axis < 3; axis++)
            begin
                walk_pos[axis] = 0;
                walk_sub[axis] = 0;
                walk_blk[axis] = 0;
            end
        end
        @(negedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample in bursts with random gaps; predict on the transfer
    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input bit known,
                               input block_result_t known_result);
        int            gap;
        bit            produced;
        block_result_t predicted;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(100, 200);
            end
            else
            begin
                gap        = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 24);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        accumulate_block_sum(value, produced, predicted);
        if (produced)
        begin
            pending_sums.push_back(known ? known_result : predicted);
        end
    endtask

    // Hold the input until every block sum is out, then let the pipeline empty
    task automatic drain_results(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                                input logic [CFG_DATA_W-1:0] sz, input logic [CFG_DATA_W-1:0] bx,
                                input logic [CFG_DATA_W-1:0] by, input logic [CFG_DATA_W-1:0] bz);
        drain_results(SETTLE_CYCLES);
        write_register(REG_SIZE_X, sx);
        write_register(REG_SIZE_Y, sy);
        write_register(REG_SIZE_Z, sz);
        write_register(REG_BLOCK_X, bx);
        write_register(REG_BLOCK_Y, by);
        write_register(REG_BLOCK_Z, bz);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return SAMPLE_W'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom;
        endcase
    endfunction

    task automatic feed_samples(input int count);
        repeat (count) push_sample(pick_sample(), 1'b0, '0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_size(input int top);
        if ($urandom_range(0, 9) == 0)
        begin
            return '0;
        end
        return CFG_DATA_W'($urandom_range(1, top));
    endfunction

    // Block codes carry random junk above the 5 bits the register keeps
    function automatic logic [CFG_DATA_W-1:0] pick_block_code();
        logic [CFG_DATA_W-1:0] code;
        int                    pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            code = '0;
        end
        else if (pick == 1)
        begin
            code = CFG_DATA_W'($urandom_range(17, 31));
        end
        else if (pick == 2)
        begin
            code = CFG_DATA_W'(MAX_BLOCK);
        end
        else
        begin
            code = CFG_DATA_W'($urandom_range(1, 3));
        end
        return code | (CFG_DATA_W'($urandom_range(0, 255)) << BLOCK_REG_W);
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] index,
                                            input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data;
        return row;
    endfunction

    function automatic stim_row_t sample_row(input logic [SAMPLE_W-1:0] value);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_SAMPLE;
        row.value = value;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic [SAMPLE_W-1:0] value,
                                            input logic [SUM_W-1:0] sum,
                                            input logic [COORD_W-1:0] x, input logic done);
        stim_row_t row;
        row               = '0;
        row.kind          = ROW_KNOWN;
        row.value         = value;
        row.expected.sum  = sum;
        row.expected.x    = x;
        row.expected.done = done;
        return row;
    endfunction

    task automatic note_mismatch(input string field, input logic [SUM_W-1:0] want,
                                 input logic [SUM_W-1:0] got);
        if (error_count < PRINT_LIMIT)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        end
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_result
        block_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                if (error_count < PRINT_LIMIT)
                begin
                    $display("%0t: unexpected result: expected none, actual sum %h at (%0d,%0d,%0d)",
                             $time, block_sum, out_x, out_y, out_z);
                end
                error_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (block_sum !== want.sum)
                begin
                    note_mismatch("block_sum", want.sum, block_sum);
                end
                if (out_x !== want.x)
                begin
                    note_mismatch("out_x", SUM_W'(want.x), SUM_W'(out_x));
                end
                if (out_y !== want.y)
                begin
                    note_mismatch("out_y", SUM_W'(want.y), SUM_W'(out_y));
                end
                if (out_z !== want.z)
                begin
                    note_mismatch("out_z", SUM_W'(want.z), SUM_W'(out_z));
                end
                if (volume_done !== want.done)
                begin
                    note_mismatch("volume_done", SUM_W'(want.done), SUM_W'(volume_done));
                end
            end
        end
    end

    // Receiver: stall in modes of random length, plus long holds on request
    initial
    begin
        int hold_seen;
        int rx_mode;
        int rx_left;
        hold_seen = 0;
        rx_mode   = 0;
        rx_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 4);
                    rx_left = $urandom_range(10, 60);
                end
                rx_left--;
                if (rx_mode <= 1)
                begin
                    out_stall <= 1'b0;
                end
                else if (rx_mode <= 3)
                begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
                else
                begin
                    out_stall <= ($urandom_range(0, 3) != 0);
                end
            end
        end
    end

    initial
    begin
        stim_row_t             row;
        int                    random_items;
        int                    count;
        int                    half;
        logic [CFG_DATA_W-1:0] sx;
        logic [CFG_DATA_W-1:0] sy;
        logic [CFG_DATA_W-1:0] sz;

        // after reset every block is one sample, so each sum is the sample itself
        directed_rows.push_back(known_row(32'h7FFF_FFFF, 48'h0000_7FFF_FFFF, 12'd0, 1'b1));
        directed_rows.push_back(known_row(32'h8000_0000, 48'hFFFF_8000_0000, 12'd0, 1'b1));
        directed_rows.push_back(known_row(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 12'd0, 1'b1));
        directed_rows.push_back(known_row(32'h0000_0000, 48'h0000_0000_0000, 12'd0, 1'b1));
        directed_rows.push_back(known_row(32'h0001_0000, 48'h0000_0001_0000, 12'd0, 1'b1));
        // pairs along x; the upper data bits of a block write are dropped
        directed_rows.push_back(write_row(REG_SIZE_X, 13'd4));
        directed_rows.push_back(write_row(REG_BLOCK_X, 13'h1FE2));
        directed_rows.push_back(sample_row(32'h7FFF_FFFF));
        directed_rows.push_back(known_row(32'h7FFF_FFFF, 48'h0000_FFFF_FFFE, 12'd0, 1'b0));
        directed_rows.push_back(sample_row(32'h8000_0000));
        directed_rows.push_back(known_row(32'h8000_0000, 48'hFFFF_0000_0000, 12'd1, 1'b1));
        // odd width: the last column is a partial block
        directed_rows.push_back(write_row(REG_SIZE_X, 13'd5));
        directed_rows.push_back(sample_row(32'h0001_2345));
        directed_rows.push_back(sample_row(32'hFFFE_0000));
        directed_rows.push_back(sample_row(32'h0000_0001));
        directed_rows.push_back(sample_row(32'h7FFF_FFFF));
        directed_rows.push_back(sample_row(32'h8000_0000));
        // block wider than the volume, then a zero block code
        directed_rows.push_back(write_row(REG_BLOCK_X, 13'd31));
        directed_rows.push_back(sample_row(32'h1234_5678));
        directed_rows.push_back(sample_row(32'hEDCB_A987));
        directed_rows.push_back(sample_row(32'h0000_FFFF));
        directed_rows.push_back(write_row(REG_BLOCK_X, 13'd0));
        directed_rows.push_back(sample_row(32'h5555_5555));
        directed_rows.push_back(sample_row(32'hAAAA_AAAA));
        // spare indexes must not restart the walk; a real write does
        directed_rows.push_back(write_row(SPARE_INDEX_A, 13'h1FFF));
        directed_rows.push_back(write_row(SPARE_INDEX_B, 13'h0000));
        directed_rows.push_back(sample_row(32'h0F0F_0F0F));
        directed_rows.push_back(write_row(REG_SIZE_Y, 13'd1));
        directed_rows.push_back(known_row(32'h0002_0000, 48'h0000_0002_0000, 12'd0, 1'b0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_WRITE:
                begin
                    drain_results(SETTLE_CYCLES);
                    write_register(row.index, row.data);
                end
                ROW_SAMPLE: push_sample(row.value, 1'b0, '0);
                default:    push_sample(row.value, 1'b1, row.expected);
            endcase
        end

        // one result per sample while the receiver holds off: fill and stall the input
        set_geometry(13'd8, 13'd4, 13'd2, 13'd1, 13'd1, 13'd0);
        hold_token++;
        burst_left = 80;
        feed_samples(64);
        random_items = 64;

        while (random_items < RANDOM_ITEMS)
        begin
            sx = pick_size(8);
            sy = pick_size(6);
            sz = pick_size(5);
            set_geometry(sx, sy, sz, pick_block_code(), pick_block_code(), pick_block_code());
            count = size_extent(sx) * size_extent(sy) * size_extent(sz) * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
            begin
                count = $urandom_range(1, count);
            end
            if (count > RANDOM_ITEMS - random_items)
            begin
                count = RANDOM_ITEMS - random_items;
            end
            half = count / 2;
            feed_samples(half);
            // pause mid-volume until the output is empty, sometimes poke a spare index
            if ($urandom_range(0, 3) == 0)
            begin
                drain_results(SETTLE_CYCLES);
                if ($urandom_range(0, 1) == 0)
                begin
                    write_register($urandom_range(0, 1) ? SPARE_INDEX_A : SPARE_INDEX_B,
                                   CFG_DATA_W'($urandom));
                end
            end
            feed_samples(count - half);
            random_items += count;
        end

        drain_results(SETTLE_CYCLES);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
